/* sv/rvd_pkg.sv */
`default_nettype none

package rvd_pkg;

    // Field widths
    localparam int unsigned WORD_W = 32;
    localparam int unsigned REG_W  = 5;
    localparam int unsigned FMT_W  = 3;
    localparam int unsigned OP_W   = 6;
    localparam int unsigned WR_W   = 6;
    localparam int unsigned WB_W   = 2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [REG_W-1:0]  t_reg;
    typedef logic [FMT_W-1:0]  t_fmt;
    typedef logic [OP_W-1:0]   t_op;
    typedef logic [WR_W-1:0]   t_wreg;
    typedef logic [WB_W-1:0]   t_wb;
    typedef logic [6:0]        t_opcode;

    // Register count; also the "no register write" marker
    localparam t_wreg REGS = 6'd32;

    // Major opcodes
    localparam t_opcode OPC_OP      = 7'h33;
    localparam t_opcode OPC_OP_32   = 7'h3b;
    localparam t_opcode OPC_LOAD    = 7'h03;
    localparam t_opcode OPC_OP_IMM  = 7'h13;
    localparam t_opcode OPC_OP_IMMW = 7'h1b;
    localparam t_opcode OPC_JALR    = 7'h67;
    localparam t_opcode OPC_SYSTEM  = 7'h73;
    localparam t_opcode OPC_STORE   = 7'h23;
    localparam t_opcode OPC_BRANCH  = 7'h63;
    localparam t_opcode OPC_AUIPC   = 7'h17;
    localparam t_opcode OPC_LUI     = 7'h37;
    localparam t_opcode OPC_JAL     = 7'h6f;

    // funct7 / funct6 patterns
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULD = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_BASE = 6'h00;
    localparam logic [5:0] F6_ALT  = 6'h10;

    // Format classes
    localparam t_fmt FMT_NONE = 3'd0;
    localparam t_fmt FMT_R    = 3'd1;
    localparam t_fmt FMT_I    = 3'd2;
    localparam t_fmt FMT_S    = 3'd3;
    localparam t_fmt FMT_B    = 3'd4;
    localparam t_fmt FMT_U    = 3'd5;
    localparam t_fmt FMT_J    = 3'd6;

    // Write-back sources
    localparam t_wb WB_NONE = 2'd0;
    localparam t_wb WB_PC4  = 2'd1;
    localparam t_wb WB_ALU  = 2'd2;
    localparam t_wb WB_LOAD = 2'd3;

    // Operation codes
    localparam t_op OP_NONE  = 6'd0;
    localparam t_op OP_ADD   = 6'd1;
    localparam t_op OP_MUL   = 6'd2;
    localparam t_op OP_SUB   = 6'd3;
    localparam t_op OP_SLL   = 6'd4;
    localparam t_op OP_MULH  = 6'd5;
    localparam t_op OP_SLT   = 6'd6;
    localparam t_op OP_XOR   = 6'd7;
    localparam t_op OP_DIV   = 6'd8;
    localparam t_op OP_SRL   = 6'd9;
    localparam t_op OP_SRA   = 6'd10;
    localparam t_op OP_OR    = 6'd11;
    localparam t_op OP_REM   = 6'd12;
    localparam t_op OP_AND   = 6'd13;
    localparam t_op OP_ADDW  = 6'd14;
    localparam t_op OP_MULW  = 6'd15;
    localparam t_op OP_SUBW  = 6'd16;
    localparam t_op OP_SLLW  = 6'd17;
    localparam t_op OP_DIVW  = 6'd18;
    localparam t_op OP_SRLW  = 6'd19;
    localparam t_op OP_DIVUW = 6'd20;
    localparam t_op OP_SRAW  = 6'd21;
    localparam t_op OP_REMW  = 6'd22;
    localparam t_op OP_REMUW = 6'd23;
    localparam t_op OP_LB    = 6'd24;
    localparam t_op OP_LH    = 6'd25;
    localparam t_op OP_LW    = 6'd26;
    localparam t_op OP_LD    = 6'd27;
    localparam t_op OP_ADDI  = 6'd28;
    localparam t_op OP_SLLI  = 6'd29;
    localparam t_op OP_SLTI  = 6'd30;
    localparam t_op OP_XORI  = 6'd31;
    localparam t_op OP_SRLI  = 6'd32;
    localparam t_op OP_SRAI  = 6'd33;
    localparam t_op OP_ORI   = 6'd34;
    localparam t_op OP_ANDI  = 6'd35;
    localparam t_op OP_ADDIW = 6'd36;
    localparam t_op OP_SLLIW = 6'd37;
    localparam t_op OP_SRLIW = 6'd38;
    localparam t_op OP_SRAIW = 6'd39;
    localparam t_op OP_JALR  = 6'd40;
    localparam t_op OP_ECALL = 6'd41;
    localparam t_op OP_SB    = 6'd42;
    localparam t_op OP_SH    = 6'd43;
    localparam t_op OP_SW    = 6'd44;
    localparam t_op OP_SD    = 6'd45;
    localparam t_op OP_BEQ   = 6'd46;
    localparam t_op OP_BNE   = 6'd47;
    localparam t_op OP_BLT   = 6'd48;
    localparam t_op OP_BGE   = 6'd49;
    localparam t_op OP_AUIPC = 6'd50;
    localparam t_op OP_LUI   = 6'd51;
    localparam t_op OP_JAL   = 6'd52;

    // Decode bundle handed from the decode logic to the result register
    typedef struct packed {
        t_fmt  format_class;
        t_op   op_code;
        t_reg  dest_reg;
        t_reg  src1_reg;
        t_reg  src2_reg;
        t_word immediate;
        t_wreg write_reg;
        t_wb   wb_source;
    } t_decode;

endpackage

`default_nettype wire

/* sv/rvd_decode.sv */
`default_nettype none

module rvd_decode (
    input  var rvd_pkg::t_word   i_instr_word,
    output var rvd_pkg::t_decode o_decode
);
    import rvd_pkg::*;

    t_opcode    opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [5:0] f6;
    t_fmt       fmt;
    t_op        op;
    t_wb        wb;
    t_word      imm;
    t_word      w;

    assign w   = i_instr_word;
    assign opc = w[6:0];
    assign f3  = w[14:12];
    assign f7  = w[31:25];
    assign f6  = w[31:26];

    // Format class and write-back source follow the major opcode alone
    always_comb begin
        case (opc)
            OPC_OP, OPC_OP_32: begin
                fmt = FMT_R;
                wb  = WB_ALU;
            end
            OPC_LOAD: begin
                fmt = FMT_I;
                wb  = WB_LOAD;
            end
            OPC_OP_IMM, OPC_OP_IMMW: begin
                fmt = FMT_I;
                wb  = WB_ALU;
            end
            OPC_JALR: begin
                fmt = FMT_I;
                wb  = WB_PC4;
            end
            OPC_SYSTEM: begin
                fmt = FMT_I;
                wb  = WB_NONE;
            end
            OPC_STORE: begin
                fmt = FMT_S;
                wb  = WB_NONE;
            end
            OPC_BRANCH: begin
                fmt = FMT_B;
                wb  = WB_NONE;
            end
            OPC_AUIPC, OPC_LUI: begin
                fmt = FMT_U;
                wb  = WB_ALU;
            end
            OPC_JAL: begin
                fmt = FMT_J;
                wb  = WB_PC4;
            end
            default: begin
                fmt = FMT_NONE;
                wb  = WB_NONE;
            end
        endcase
    end

    // Operation code: opcode plus funct3/funct7 checks
    always_comb begin
        op = OP_NONE;
        case (opc)
            OPC_OP: begin
                case (f3)
                    3'd0: begin
                        if (f7 == F7_BASE)      op = OP_ADD;
                        else if (f7 == F7_MULD) op = OP_MUL;
                        else if (f7 == F7_ALT)  op = OP_SUB;
                    end
                    3'd1: begin
                        if (f7 == F7_BASE)      op = OP_SLL;
                        else if (f7 == F7_MULD) op = OP_MULH;
                    end
                    3'd2: begin
                        if (f7 == F7_BASE) op = OP_SLT;
                    end
                    3'd4: begin
                        if (f7 == F7_BASE)      op = OP_XOR;
                        else if (f7 == F7_MULD) op = OP_DIV;
                    end
                    3'd5: begin
                        if (f7 == F7_BASE)     op = OP_SRL;
                        else if (f7 == F7_ALT) op = OP_SRA;
                    end
                    3'd6: begin
                        if (f7 == F7_BASE)      op = OP_OR;
                        else if (f7 == F7_MULD) op = OP_REM;
                    end
                    3'd7: begin
                        if (f7 == F7_BASE) op = OP_AND;
                    end
                    default: op = OP_NONE;
                endcase
            end
            OPC_OP_32: begin
                case (f3)
                    3'd0: begin
                        if (f7 == F7_BASE)      op = OP_ADDW;
                        else if (f7 == F7_MULD) op = OP_MULW;
                        else if (f7 == F7_ALT)  op = OP_SUBW;
                    end
                    3'd1: begin
                        if (f7 == F7_BASE) op = OP_SLLW;
                    end
                    3'd4: begin
                        if (f7 == F7_MULD) op = OP_DIVW;
                    end
                    3'd5: begin
                        if (f7 == F7_BASE)      op = OP_SRLW;
                        else if (f7 == F7_MULD) op = OP_DIVUW;
                        else if (f7 == F7_ALT)  op = OP_SRAW;
                    end
                    3'd6: begin
                        if (f7 == F7_MULD) op = OP_REMW;
                    end
                    3'd7: begin
                        if (f7 == F7_MULD) op = OP_REMUW;
                    end
                    default: op = OP_NONE;
                endcase
            end
            OPC_LOAD: begin
                if (!f3[2]) op = OP_LB + {3'b000, f3};
            end
            OPC_OP_IMM: begin
                case (f3)
                    3'd0: op = OP_ADDI;
                    3'd1: begin
                        if (f6 == F6_BASE) op = OP_SLLI;
                    end
                    3'd2: op = OP_SLTI;
                    3'd4: op = OP_XORI;
                    3'd5: begin
                        if (f6 == F6_BASE)     op = OP_SRLI;
                        else if (f6 == F6_ALT) op = OP_SRAI;
                    end
                    3'd6: op = OP_ORI;
                    3'd7: op = OP_ANDI;
                    default: op = OP_NONE;
                endcase
            end
            OPC_OP_IMMW: begin
                case (f3)
                    3'd0: op = OP_ADDIW;
                    3'd1: begin
                        if (f7 == F7_BASE) op = OP_SLLIW;
                    end
                    3'd5: begin
                        if (f7 == F7_BASE)     op = OP_SRLIW;
                        else if (f7 == F7_ALT) op = OP_SRAIW;
                    end
                    default: op = OP_NONE;
                endcase
            end
            OPC_JALR: begin
                if (f3 == 3'd0) op = OP_JALR;
            end
            OPC_SYSTEM: begin
                if (f3 == 3'd0 && f7 == F7_BASE) op = OP_ECALL;
            end
            OPC_STORE: begin
                if (!f3[2]) op = OP_SB + {3'b000, f3};
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0: op = OP_BEQ;
                    3'd1: op = OP_BNE;
                    3'd4: op = OP_BLT;
                    3'd5: op = OP_BGE;
                    default: op = OP_NONE;
                endcase
            end
            OPC_AUIPC: op = OP_AUIPC;
            OPC_LUI:   op = OP_LUI;
            OPC_JAL:   op = OP_JAL;
            default:   op = OP_NONE;
        endcase
    end

    // Assemble the immediate, zero-filled above its top bit; all ones for R and undefined formats
    always_comb begin
        case (fmt)
            FMT_I:   imm = {20'd0, w[31:20]};
            FMT_S:   imm = {20'd0, w[31:25], w[11:7]};
            FMT_B:   imm = {19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_U:   imm = {w[31:12], 12'd0};
            FMT_J:   imm = {11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default: imm = '1;
        endcase
    end

    // Pack the bundle
    always_comb begin
        o_decode.format_class = fmt;
        o_decode.op_code      = op;
        o_decode.dest_reg     = w[11:7];
        o_decode.src1_reg     = w[19:15];
        o_decode.src2_reg     = w[24:20];
        o_decode.immediate    = imm;
        o_decode.write_reg    = (wb != WB_NONE) ? {1'b0, w[11:7]} : REGS;
        o_decode.wb_source    = wb;
    end

endmodule

`default_nettype wire

/* sv/rv64im_instruction_decoder.sv */
`default_nettype none

// Decodes one RV64IM instruction word per clock into format class, operation
// code, register fields, raw (not sign-extended) immediate, write register and
// write-back source. Pulse start with i_instr_word to issue a word; busy is
// always low, so a word may be issued every cycle. Each word gives exactly one
// result, passing first the input register and then the result register, with
// the decode logic between them. o_done marks that result for a single cycle
// and there is no way to stall it, so the receiver must take it in that cycle.
// Write register 32 means no register is written.
module rv64im_instruction_decoder (
    input  var logic           i_clk,
    input  var logic           i_rst_n,
    input  var logic           start,
    output var logic           busy,
    input  var rvd_pkg::t_word i_instr_word,
    output var logic           o_done,
    output var rvd_pkg::t_fmt  o_format_class,
    output var rvd_pkg::t_op   o_op_code,
    output var rvd_pkg::t_reg  o_dest_reg,
    output var rvd_pkg::t_reg  o_src1_reg,
    output var rvd_pkg::t_reg  o_src2_reg,
    output var rvd_pkg::t_word o_immediate,
    output var rvd_pkg::t_wreg o_write_reg,
    output var rvd_pkg::t_wb   o_wb_source
);
    import rvd_pkg::*;

    logic    r_in_valid;
    t_word   r_instr_word;
    logic    r_out_valid;
    t_decode r_result;
    t_decode n_result;

    // Never stall the issuer
    assign busy = 1'b0;

    // Capture the incoming beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_instr_word <= i_instr_word;
        end
    end

    rvd_decode u_decode (
        .i_instr_word (r_instr_word),
        .o_decode     (n_result)
    );

    // Register the decoded beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    // Drive the result ports
    assign o_done         = r_out_valid;
    assign o_format_class = r_result.format_class;
    assign o_op_code      = r_result.op_code;
    assign o_dest_reg     = r_result.dest_reg;
    assign o_src1_reg     = r_result.src1_reg;
    assign o_src2_reg     = r_result.src2_reg;
    assign o_immediate    = r_result.immediate;
    assign o_write_reg    = r_result.write_reg;
    assign o_wb_source    = r_result.wb_source;

`ifndef NO_ASSERTIONS
    // Every captured beat produces a result in the next cycle
    a_beat_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_done)
        else $error("captured beat did not reach the result register");

    // A register write always comes with a write-back source
    a_write_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_write_reg != REGS) |-> (o_wb_source != WB_NONE))
        else $error("register write without write-back source");

    // Register-register and undefined words carry an all-ones immediate
    a_r_imm_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_format_class == FMT_R || o_format_class == FMT_NONE)
        |-> (o_immediate == '1))
        else $error("R or undefined format with assembled immediate");

    // A recognized operation always has a known format
    a_op_has_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_op_code != OP_NONE) |-> (o_format_class != FMT_NONE))
        else $error("operation decoded with undefined format");
`endif

endmodule

`default_nettype wire
